[hdl/bcet_pkg.sv]
// shared types, constants and codes of the cyclic bch error trapping codec
package bcet_pkg;

  localparam int CODE_LENGTH = 15;
  localparam int CHECK_BITS  = 8;
  localparam int MSG_BITS    = CODE_LENGTH - CHECK_BITS;
  localparam int CNT_W       = $clog2(CODE_LENGTH);
  localparam int WGT_W       = $clog2(CHECK_BITS + 1);
  localparam int LIMIT_W     = 3;
  localparam int CMP_W       = (WGT_W > LIMIT_W) ? WGT_W : LIMIT_W;
  localparam int STATUS_W    = 2;
  localparam int GEN_W       = CHECK_BITS + 1;

  // stream payload widths
  localparam int IN_TDATA_W  = ((CODE_LENGTH + 7) / 8) * 8;
  localparam int OUT_W       = CODE_LENGTH + CHECK_BITS + STATUS_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic [CODE_LENGTH-1:0] word_t;
  typedef logic [CHECK_BITS-1:0]  par_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [WGT_W-1:0]       wgt_t;
  typedef logic [LIMIT_W-1:0]     limit_t;
  typedef logic [STATUS_W-1:0]    status_t;

  // register reset values (leading generator bit is implied)
  localparam par_t   GEN_RESET   = par_t'(465);
  localparam limit_t LIMIT_RESET = limit_t'(2);

  // configuration register indexes
  localparam logic CFG_GEN   = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // result status codes
  localparam status_t ST_OK    = status_t'(0);
  localparam status_t ST_FIXED = status_t'(1);
  localparam status_t ST_FAIL  = status_t'(2);

  // word shift register commands
  typedef enum logic [2:0] {
    ROT_HOLD,
    ROT_LOAD,
    ROT_LEFT,
    ROT_RIGHT,
    ROT_FLIP
  } rot_cmd_e;

  typedef struct packed {
    rot_cmd_e cmd;
    word_t    load_word;
  } rot_ctl_t;

  // remainder register commands
  typedef enum logic [1:0] {
    REM_HOLD,
    REM_CLEAR,
    REM_SHIFT
  } rem_cmd_e;

  typedef struct packed {
    rem_cmd_e cmd;
    logic     bit_in;
  } rem_ctl_t;

endpackage

[hdl/bcet_rem.sv]
// bit-serial polynomial divider that keeps the running remainder and its weight
module bcet_rem import bcet_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_ctl_t ctl_i,
  input  par_t     gen_i,
  output par_t     rem_o,
  output wgt_t     weight_o
);

  par_t rem_q, rem_d;
  wgt_t wgt;

  // shift in one word bit, msb first, and reduce by the generator
  always_comb begin
    rem_d = rem_q;
    case (ctl_i.cmd)
      REM_CLEAR: rem_d = '0;
      REM_SHIFT: begin
        rem_d = {rem_q[CHECK_BITS-2:0], ctl_i.bit_in};
        if (rem_q[CHECK_BITS-1]) begin
          rem_d = rem_d ^ gen_i;
        end
      end
      REM_HOLD: rem_d = rem_q;
      default:  rem_d = rem_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // weight of the remainder
  always_comb begin
    wgt = '0;
    for (int i = 0; i < CHECK_BITS; i++) begin
      wgt = wgt + wgt_t'(rem_q[i]);
    end
  end

  assign rem_o    = rem_q;
  assign weight_o = wgt;

endmodule

[hdl/bcet_rot.sv]
// circular word shift register: feeds the divider and applies the correction
module bcet_rot import bcet_pkg::*; (
  input  logic     clk_i,
  input  rot_ctl_t ctl_i,
  input  par_t     flip_i,
  output logic     msb_o,
  output word_t    word_o
);

  word_t word_q, word_d;

  // one rotation step, load or parity flip per cycle
  always_comb begin
    word_d = word_q;
    case (ctl_i.cmd)
      ROT_LOAD:  word_d = ctl_i.load_word;
      ROT_LEFT:  word_d = {word_q[CODE_LENGTH-2:0], word_q[CODE_LENGTH-1]};
      ROT_RIGHT: word_d = {word_q[0], word_q[CODE_LENGTH-1:1]};
      ROT_FLIP:  word_d = word_q ^ word_t'(flip_i);
      ROT_HOLD:  word_d = word_q;
      default:   word_d = word_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign msb_o  = word_q[CODE_LENGTH-1];
  assign word_o = word_q;

endmodule

[hdl/cyclic_bch_error_trapping_codec.sv]
// top level of the cyclic bch (15,7) encoder and error trapping decoder
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata data_word, tuser op
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata code_word, syndrome,
//                                                      status, shift_count
//  cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// one word at a time; the serial divider takes one word bit per cycle, and
// every remainder is followed by a check step and, before the next remainder,
// by a right rotation of the word.
// encode, zero syndrome or trap at rotation zero: result after a single division
// pass; trap at rotation h: word rotated back h steps first; uncorrectable: a pass at every rotation.
// a finished result waits in the output register while the next word enters;
// a new result stalls only if the previous one has not been taken yet.
// asynchronous active-low reset clears control state and the configuration registers.
module cyclic_bch_error_trapping_codec import bcet_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [14:0] data_word, [15] zero
  input  logic                   s_axis_tuser,  // [0] op
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [14:0] code_word, [22:15] syndrome,
                                                // [24:23] status, [28:25] shift_count,
                                                // [31:29] zero
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [GEN_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    IDLE,
    DIV,
    CHECK,
    ROTR,
    BACK,
    DONE
  } state_e;

  state_e  state_q;
  cnt_t    cnt_q;
  cnt_t    h_q;
  logic    op_q;
  word_t   orig_q;
  par_t    syn_q;
  status_t status_q;
  cnt_t    shift_q;
  logic    out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  par_t    gen_q;
  limit_t  limit_q;

  rot_ctl_t rot_ctl;
  rem_ctl_t rem_ctl;
  logic     rot_msb;
  word_t    rot_word;
  par_t     rem;
  wgt_t     rem_wgt;
  logic     in_xfer;
  logic     trapped;
  word_t    load_word;
  word_t    done_word;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // configuration registers, written only while idle
  assign cfg_ready_o = (state_q == IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q   <= GEN_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_GEN) begin
        gen_q <= cfg_data_i[CHECK_BITS-1:0];
      end else begin
        limit_q <= cfg_data_i[LIMIT_W-1:0];
      end
    end
  end

  // word to divide: received word, or message shifted above the parity
  assign load_word = (s_axis_tuser == OP_ENCODE)
                   ? {s_axis_tdata[MSG_BITS-1:0], {CHECK_BITS{1'b0}}}
                   : s_axis_tdata[CODE_LENGTH-1:0];

  assign trapped = (CMP_W'(rem_wgt) <= CMP_W'(limit_q));

  // commands to the shift registers
  always_comb begin
    rot_ctl.cmd       = ROT_HOLD;
    rot_ctl.load_word = load_word;
    rem_ctl.cmd       = REM_HOLD;
    rem_ctl.bit_in    = rot_msb;
    case (state_q)
      IDLE: begin
        if (in_xfer) begin
          rot_ctl.cmd = ROT_LOAD;
          rem_ctl.cmd = REM_CLEAR;
        end
      end
      DIV: begin
        rot_ctl.cmd = ROT_LEFT;
        rem_ctl.cmd = REM_SHIFT;
      end
      CHECK: begin
        if (op_q == OP_DECODE && rem != '0 && trapped) begin
          rot_ctl.cmd = ROT_FLIP;
        end
      end
      ROTR: begin
        rot_ctl.cmd = ROT_RIGHT;
        rem_ctl.cmd = REM_CLEAR;
      end
      BACK:    rot_ctl.cmd = ROT_LEFT;
      DONE:    rot_ctl.cmd = ROT_HOLD;
      default: rot_ctl.cmd = ROT_HOLD;
    endcase
  end

  bcet_rot u_rot (
    .clk_i  (clk_i),
    .ctl_i  (rot_ctl),
    .flip_i (rem),
    .msb_o  (rot_msb),
    .word_o (rot_word)
  );

  bcet_rem u_rem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rem_ctl),
    .gen_i    (gen_q),
    .rem_o    (rem),
    .weight_o (rem_wgt)
  );

  // result word chosen by outcome
  always_comb begin
    if (status_q == ST_FIXED) begin
      done_word = rot_word;
    end else if (op_q == OP_ENCODE) begin
      done_word = orig_q | word_t'(syn_q);
    end else begin
      done_word = orig_q;
    end
  end

  // sequencer with state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      h_q         <= '0;
      op_q        <= OP_ENCODE;
      status_q    <= ST_OK;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output transfer empties the register unless a new result replaces it
      if (m_axis_tvalid && m_axis_tready && state_q != DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_xfer) begin
            op_q     <= s_axis_tuser;
            orig_q   <= load_word;
            cnt_q    <= '0;
            h_q      <= '0;
            status_q <= ST_OK;
            shift_q  <= '0;
            state_q  <= DIV;
          end
        end
        DIV: begin
          cnt_q <= cnt_q + cnt_t'(1);
          if (cnt_q == cnt_t'(CODE_LENGTH - 1)) begin
            cnt_q   <= '0;
            state_q <= CHECK;
          end
        end
        CHECK: begin
          if (h_q == '0) begin
            syn_q <= rem;
          end
          if (op_q == OP_ENCODE || (h_q == '0 && rem == '0)) begin
            state_q <= DONE;
          end else if (trapped) begin
            status_q <= ST_FIXED;
            shift_q  <= h_q;
            state_q  <= (h_q == '0) ? DONE : BACK;
          end else if (h_q == cnt_t'(CODE_LENGTH - 1)) begin
            status_q <= ST_FAIL;
            state_q  <= DONE;
          end else begin
            state_q <= ROTR;
          end
        end
        ROTR: begin
          h_q     <= h_q + cnt_t'(1);
          state_q <= DIV;
        end
        BACK: begin
          cnt_q <= cnt_q + cnt_t'(1);
          if (cnt_q + cnt_t'(1) == h_q) begin
            cnt_q   <= '0;
            state_q <= DONE;
          end
        end
        DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= OUT_TDATA_W'({shift_q, status_q, syn_q, done_word});
            state_q     <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // every accepted word starts a division pass
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == DIV)
    else $error("accepted word did not start a division");

  // a full division pass leaves the word register where it started
  a_word_restored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CHECK && h_q == '0) |-> rot_word == orig_q)
    else $error("word register not restored after division");

  // rotating back only happens for a nonzero trap rotation
  a_back_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BACK |-> (h_q != '0 && status_q == ST_FIXED))
    else $error("rotate back without a trapped rotation");

  // a corrected result always carries a nonzero syndrome
  a_fixed_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[CODE_LENGTH+CHECK_BITS+STATUS_W-1:
                                   CODE_LENGTH+CHECK_BITS] == ST_FIXED)
    |-> m_axis_tdata[CODE_LENGTH+CHECK_BITS-1:CODE_LENGTH] != '0)
    else $error("corrected result with zero syndrome");
`endif

endmodule
